FILE: design/nhr_pkg.sv
// ----------------------------------------------------------------------------
// nhr_pkg
// Shared codes, widths and control bundles of the next hop resolver.
// ----------------------------------------------------------------------------
package nhr_pkg;

	localparam int unsigned DEF_ROUTE_DEPTH    = 128;
	localparam int unsigned DEF_NEIGHBOR_DEPTH = 128;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned IDX_W   = 7;
	localparam int unsigned IP_W    = 32;
	localparam int unsigned PORT_W  = 2;
	localparam int unsigned MAC_W   = 48;
	localparam int unsigned CFG_A_W = 8;
	localparam int unsigned CFG_D_W = 8;

	localparam logic [OP_W-1:0] OP_LOOKUP    = 2'd0;
	localparam logic [OP_W-1:0] OP_ROUTE_WR  = 2'd1;
	localparam logic [OP_W-1:0] OP_NBR_WR    = 2'd2;

	localparam logic [CFG_A_W-1:0] REG_ROUTE_USED    = 8'd0;
	localparam logic [CFG_A_W-1:0] REG_NEIGHBOR_USED = 8'd1;

	typedef struct packed {
		logic wr_route;
		logic wr_nbr;
		logic start;
		logic rd_route;
		logic rd_nbr;
		logic load_out;
	} nhr_cmd_t;

	typedef struct packed {
		logic route_found;
		logic rsp_free;
	} nhr_status_t;

endpackage

FILE: design/nhr_ctrl.sv
// ----------------------------------------------------------------------------
// nhr_ctrl
// Sequencer: takes requests, runs the route scan and the neighbor scan,
// holds the two entry count registers.
// ----------------------------------------------------------------------------
module nhr_ctrl
	import nhr_pkg::*;
#(
	parameter int unsigned ROUTE_DEPTH    = DEF_ROUTE_DEPTH,
	parameter int unsigned NEIGHBOR_DEPTH = DEF_NEIGHBOR_DEPTH,
	localparam int unsigned RAW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1,
	localparam int unsigned NAW = (NEIGHBOR_DEPTH > 1) ? $clog2(NEIGHBOR_DEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [OP_W-1:0]    operation,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_A_W-1:0] cfg_index,
	input  logic [CFG_D_W-1:0] cfg_data,
	output nhr_cmd_t           cmd,
	input  nhr_status_t        status,
	output logic [RAW-1:0]     route_addr,
	output logic [NAW-1:0]     nbr_addr
);

	localparam int unsigned MAXD = (ROUTE_DEPTH > NEIGHBOR_DEPTH) ? ROUTE_DEPTH
		: NEIGHBOR_DEPTH;
	localparam int unsigned CW = $clog2(MAXD + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RSCAN  = 3'd1;
	localparam logic [2:0] S_RDRAIN = 3'd2;
	localparam logic [2:0] S_NSCAN  = 3'd3;
	localparam logic [2:0] S_NDRAIN = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0]         state_q, state_d;
	logic [CW-1:0]      idx_q, idx_d, idx_inc;
	logic               dcnt_q, dcnt_d;
	logic [CFG_D_W-1:0] route_used_q, nbr_used_q;
	logic [CW-1:0]      rlim, nlim;
	logic               accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_used_q <= '0;
			nbr_used_q   <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_ROUTE_USED)
				route_used_q <= cfg_data;
			else if (cfg_index == REG_NEIGHBOR_USED)
				nbr_used_q <= cfg_data;
		end
	end

	// counts above the table depth saturate
	assign rlim = (32'(route_used_q) > ROUTE_DEPTH) ? CW'(ROUTE_DEPTH) : CW'(route_used_q);
	assign nlim = (32'(nbr_used_q) > NEIGHBOR_DEPTH) ? CW'(NEIGHBOR_DEPTH)
		: CW'(nbr_used_q);

	assign req_stall  = (state_q != S_IDLE);
	assign accept     = req_valid && !req_stall;
	assign idx_inc    = idx_q + CW'(1);
	assign route_addr = idx_q[RAW-1:0];
	assign nbr_addr   = idx_q[NAW-1:0];

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		dcnt_d  = dcnt_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.wr_route = (operation == OP_ROUTE_WR);
					cmd.wr_nbr   = (operation == OP_NBR_WR);
					if (operation == OP_LOOKUP) begin
						cmd.start = 1'b1;
						idx_d     = '0;
						dcnt_d    = 1'b0;
						state_d   = (rlim == '0) ? S_RDRAIN : S_RSCAN;
					end
				end
			end
			S_RSCAN: begin
				cmd.rd_route = 1'b1;
				idx_d        = idx_inc;
				if (idx_inc == rlim) begin
					dcnt_d  = 1'b0;
					state_d = S_RDRAIN;
				end
			end
			S_RDRAIN: begin
				// wait, via dcnt, until the last route entry has been ranked
				dcnt_d = 1'b1;
				if (dcnt_q) begin
					idx_d   = '0;
					state_d = S_NSCAN;
				end
			end
			S_NSCAN: begin
				if (!status.route_found || nlim == '0) begin
					state_d = S_OUT;
				end else begin
					cmd.rd_nbr = 1'b1;
					idx_d      = idx_inc;
					if (idx_inc == nlim)
						state_d = S_NDRAIN;
				end
			end
			S_NDRAIN: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (status.rsp_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			dcnt_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			dcnt_q  <= dcnt_d;
		end
	end

endmodule

FILE: design/nhr_datapath.sv
// ----------------------------------------------------------------------------
// nhr_datapath
// Route and neighbor tables, the match/rank pipeline, best-route and
// neighbor hit registers, and the result register.
// ----------------------------------------------------------------------------
module nhr_datapath
	import nhr_pkg::*;
#(
	parameter int unsigned ROUTE_DEPTH    = DEF_ROUTE_DEPTH,
	parameter int unsigned NEIGHBOR_DEPTH = DEF_NEIGHBOR_DEPTH,
	localparam int unsigned RAW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1,
	localparam int unsigned NAW = (NEIGHBOR_DEPTH > 1) ? $clog2(NEIGHBOR_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nhr_cmd_t          cmd,
	output nhr_status_t       status,
	input  logic [RAW-1:0]    route_addr,
	input  logic [NAW-1:0]    nbr_addr,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [IP_W-1:0]   ip_addr,
	input  logic [IP_W-1:0]   net_mask,
	input  logic [IP_W-1:0]   hop_addr,
	input  logic [PORT_W-1:0] port_num,
	input  logic [MAC_W-1:0]  hw_addr,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              route_found,
	output logic [PORT_W-1:0] out_port,
	output logic [IP_W-1:0]   next_hop_ip,
	output logic              neighbor_found,
	output logic [MAC_W-1:0]  dest_mac
);

	// top-aligned run of ones in a mask: bit i set when bits 31..i are all set.
	// Longer prefixes give larger codes, so ranks compare as plain numbers.
	function automatic logic [IP_W-1:0] lead_ones(input logic [IP_W-1:0] m);
		logic [IP_W-1:0] t;
		t = m;
		for (int k = 1; k < IP_W; k = k * 2)
			t = t & ~((~t) >> k);
		return t;
	endfunction

	logic [IP_W-1:0]   prefix_mem [ROUTE_DEPTH];
	logic [IP_W-1:0]   mask_mem   [ROUTE_DEPTH];
	logic [IP_W-1:0]   hop_mem    [ROUTE_DEPTH];
	logic [PORT_W-1:0] port_mem   [ROUTE_DEPTH];
	logic [IP_W-1:0]   nip_mem    [NEIGHBOR_DEPTH];
	logic [MAC_W-1:0]  nmac_mem   [NEIGHBOR_DEPTH];

	logic [IP_W-1:0]   dest_q;
	logic              rvld_s1, rvld_s2, nvld_s1;
	logic [IP_W-1:0]   pfx_s1, msk_s1, hop_s1, nip_s1;
	logic [PORT_W-1:0] prt_s1, prt_s2;
	logic [MAC_W-1:0]  nmac_s1;
	logic              match_s2;
	logic [IP_W-1:0]   rank_s2, hop_s2;
	logic              found_q, nfound_q;
	logic [IP_W-1:0]   best_rank_q, best_hop_q;
	logic [PORT_W-1:0] best_port_q;
	logic [MAC_W-1:0]  mac_q;
	logic              route_wr_ok, nbr_wr_ok;

	assign route_wr_ok = (32'(entry_index) < ROUTE_DEPTH);
	assign nbr_wr_ok   = (32'(entry_index) < NEIGHBOR_DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.wr_route && route_wr_ok) begin
			prefix_mem[RAW'(entry_index)] <= ip_addr;
			mask_mem[RAW'(entry_index)]   <= net_mask;
			hop_mem[RAW'(entry_index)]    <= hop_addr;
			port_mem[RAW'(entry_index)]   <= port_num;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_route) begin
			pfx_s1 <= prefix_mem[route_addr];
			msk_s1 <= mask_mem[route_addr];
			hop_s1 <= hop_mem[route_addr];
			prt_s1 <= port_mem[route_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_nbr && nbr_wr_ok) begin
			nip_mem[NAW'(entry_index)]  <= ip_addr;
			nmac_mem[NAW'(entry_index)] <= hw_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_nbr) begin
			nip_s1  <= nip_mem[nbr_addr];
			nmac_s1 <= nmac_mem[nbr_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start)
			dest_q <= ip_addr;
		match_s2 <= ((dest_q & msk_s1) == pfx_s1);
		rank_s2  <= lead_ones(msk_s1);
		hop_s2   <= hop_s1;
		prt_s2   <= prt_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
			rvld_s2 <= 1'b0;
			nvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= cmd.rd_route;
			rvld_s2 <= rvld_s1;
			nvld_s1 <= cmd.rd_nbr;
		end
	end

	// strict compare keeps the first of equally long matches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			nfound_q <= 1'b0;
		end else if (cmd.start) begin
			found_q  <= 1'b0;
			nfound_q <= 1'b0;
		end else begin
			if (rvld_s2 && match_s2 && (!found_q || rank_s2 > best_rank_q))
				found_q <= 1'b1;
			if (nvld_s1 && !nfound_q && nip_s1 == best_hop_q)
				nfound_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s2 && match_s2 && (!found_q || rank_s2 > best_rank_q)) begin
			best_rank_q <= rank_s2;
			best_hop_q  <= hop_s2;
			best_port_q <= prt_s2;
		end
		if (nvld_s1 && !nfound_q && nip_s1 == best_hop_q)
			mac_q <= nmac_s1;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid <= 1'b0;
		else if (cmd.load_out)
			rsp_valid <= 1'b1;
		else if (!rsp_stall)
			rsp_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			route_found    <= found_q;
			out_port       <= found_q ? best_port_q : '0;
			next_hop_ip    <= found_q ? best_hop_q : '0;
			neighbor_found <= nfound_q;
			dest_mac       <= nfound_q ? mac_q : '0;
		end
	end

	assign status.route_found = found_q;
	assign status.rsp_free    = !rsp_valid || !rsp_stall;

endmodule

FILE: design/ipv4_next_hop_resolver.sv
// ----------------------------------------------------------------------------
// ipv4_next_hop_resolver
// Longest prefix match over a route table, then a neighbor table search for
// the chosen next hop.
//
//   channel | handshake            | beat contents
//   --------+----------------------+-------------------------------------------
//   req     | req_valid/req_stall  | operation, entry_index, ip_addr, net_mask,
//           |                      | hop_addr, port_num, hw_addr
//   rsp     | rsp_valid/rsp_stall  | route_found, out_port, next_hop_ip,
//           |                      | neighbor_found, dest_mac
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A lookup scans R route entries and then N neighbor entries, R and N being
// the searched route and neighbor counts (N is 0 if no route matched); one
// table entry is read per cycle. Reset clears the counts and control state;
// tables hold until written. The result register frees the input while a
// stalled result waits; the next lookup then holds at its end until rsp
// frees up.
// ----------------------------------------------------------------------------
module ipv4_next_hop_resolver
	import nhr_pkg::*;
#(
	parameter int unsigned ROUTE_DEPTH    = DEF_ROUTE_DEPTH,
	parameter int unsigned NEIGHBOR_DEPTH = DEF_NEIGHBOR_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [OP_W-1:0]    operation,
	input  logic [IDX_W-1:0]   entry_index,
	input  logic [IP_W-1:0]    ip_addr,
	input  logic [IP_W-1:0]    net_mask,
	input  logic [IP_W-1:0]    hop_addr,
	input  logic [PORT_W-1:0]  port_num,
	input  logic [MAC_W-1:0]   hw_addr,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               route_found,
	output logic [PORT_W-1:0]  out_port,
	output logic [IP_W-1:0]    next_hop_ip,
	output logic               neighbor_found,
	output logic [MAC_W-1:0]   dest_mac,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_A_W-1:0] cfg_index,
	input  logic [CFG_D_W-1:0] cfg_data
);

	localparam int unsigned RAW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
	localparam int unsigned NAW = (NEIGHBOR_DEPTH > 1) ? $clog2(NEIGHBOR_DEPTH) : 1;

	nhr_cmd_t       cmd;
	nhr_status_t    status;
	logic [RAW-1:0] route_addr;
	logic [NAW-1:0] nbr_addr;

	nhr_ctrl #(
		.ROUTE_DEPTH    (ROUTE_DEPTH),
		.NEIGHBOR_DEPTH (NEIGHBOR_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.operation  (operation),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.status     (status),
		.route_addr (route_addr),
		.nbr_addr   (nbr_addr)
	);

	nhr_datapath #(
		.ROUTE_DEPTH    (ROUTE_DEPTH),
		.NEIGHBOR_DEPTH (NEIGHBOR_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.route_addr     (route_addr),
		.nbr_addr       (nbr_addr),
		.entry_index    (entry_index),
		.ip_addr        (ip_addr),
		.net_mask       (net_mask),
		.hop_addr       (hop_addr),
		.port_num       (port_num),
		.hw_addr        (hw_addr),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.route_found    (route_found),
		.out_port       (out_port),
		.next_hop_ip    (next_hop_ip),
		.neighbor_found (neighbor_found),
		.dest_mac       (dest_mac)
	);

endmodule

FILE: sim/tb_ipv4_next_hop_resolver.sv
// ----------------------------------------------------------------------------
// tb_ipv4_next_hop_resolver
// Self-checking bench for the next hop resolver. A short table of directed
// beats covers reset state, table extremes, ties, masks with holes and the
// dropped opcode. Both tables are then filled, and random traffic runs under
// a range of searched counts. Every lookup result is checked field by field
// against a local longest-prefix-match model or a written expectation. Both
// channels idle at random.
module tb_ipv4_next_hop_resolver;

	import nhr_pkg::*;

	localparam int unsigned ROUTES    = DEF_ROUTE_DEPTH;
	localparam int unsigned NBRS      = DEF_NEIGHBOR_DEPTH;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	// worst lookup scans all 128 route and 128 neighbor entries
	localparam int unsigned SETTLE    = 300;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned LIMIT     = 1000000;
	localparam int unsigned PHASES    = 6;
	localparam int unsigned PHASE_LEN = 50;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  idx;
		logic [IP_W-1:0]   ip;
		logic [IP_W-1:0]   mask;
		logic [IP_W-1:0]   hop;
		logic [PORT_W-1:0] port;
		logic [MAC_W-1:0]  mac;
	} route_req_t;

	typedef struct packed {
		logic              found;
		logic [PORT_W-1:0] port;
		logic [IP_W-1:0]   hop;
		logic              nb_found;
		logic [MAC_W-1:0]  mac;
	} hop_res_t;

	typedef struct {
		bit            is_cfg;
		bit            typed;
		logic [7:0]    rt_cnt;
		logic [7:0]    nb_cnt;
		route_req_t    req;
		hop_res_t      want;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [OP_W-1:0]    operation;
	logic [IDX_W-1:0]   entry_index;
	logic [IP_W-1:0]    ip_addr;
	logic [IP_W-1:0]    net_mask;
	logic [IP_W-1:0]    hop_addr;
	logic [PORT_W-1:0]  port_num;
	logic [MAC_W-1:0]   hw_addr;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic               route_found;
	logic [PORT_W-1:0]  out_port;
	logic [IP_W-1:0]    next_hop_ip;
	logic               neighbor_found;
	logic [MAC_W-1:0]   dest_mac;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_A_W-1:0] cfg_index;
	logic [CFG_D_W-1:0] cfg_data;

	// local copy of the tables and counts
	logic [IP_W-1:0]   rt_prefix [ROUTES];
	logic [IP_W-1:0]   rt_mask   [ROUTES];
	logic [IP_W-1:0]   rt_hop    [ROUTES];
	logic [PORT_W-1:0] rt_port   [ROUTES];
	logic [IP_W-1:0]   nb_ip     [NBRS];
	logic [MAC_W-1:0]  nb_mac    [NBRS];
	logic [7:0]        rt_used = '0;
	logic [7:0]        nb_used = '0;

	hop_res_t          hop_q [$];
	dir_row_t          dir_tbl [$];
	logic [IP_W-1:0]   hop_pool [16];

	int unsigned       fail_cnt = 0;
	int unsigned       cycle_cnt = 0;
	int unsigned       req_gap_pct = 0;
	int unsigned       rsp_stall_pct = 0;
	int unsigned       stall_left = 0;
	bit                long_hold_go = 1'b0;
	bit                long_hold_done = 1'b0;

	ipv4_next_hop_resolver i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.operation      (operation),
		.entry_index    (entry_index),
		.ip_addr        (ip_addr),
		.net_mask       (net_mask),
		.hop_addr       (hop_addr),
		.port_num       (port_num),
		.hw_addr        (hw_addr),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.route_found    (route_found),
		.out_port       (out_port),
		.next_hop_ip    (next_hop_ip),
		.neighbor_found (neighbor_found),
		.dest_mac       (dest_mac),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ones counted down from bit 31; holes below the first zero do not rank
	function automatic int unsigned mask_ones(input logic [IP_W-1:0] m);
		int unsigned n;
		n = 0;
		while (n < 32 && m[31-n])
			n++;
		return n;
	endfunction

	function automatic hop_res_t resolve_next_hop(input logic [IP_W-1:0] dest);
		hop_res_t    r;
		int unsigned rn, nn, best, best_len, len;
		bit          hit;
		r = '0;
		hit = 1'b0;
		best = 0;
		best_len = 0;
		rn = (rt_used > ROUTES) ? ROUTES : rt_used;
		nn = (nb_used > NBRS) ? NBRS : nb_used;
		for (int unsigned i = 0; i < rn; i++) begin
			if ((dest & rt_mask[i]) == rt_prefix[i]) begin
				len = mask_ones(rt_mask[i]);
				// strict compare keeps the first entry on a tie
				if (!hit || len > best_len) begin
					hit = 1'b1;
					best_len = len;
					best = i;
				end
			end
		end
		if (hit) begin
			r.found = 1'b1;
			r.port = rt_port[best];
			r.hop = rt_hop[best];
			for (int unsigned i = 0; i < nn; i++) begin
				if (!r.nb_found && nb_ip[i] == r.hop) begin
					r.nb_found = 1'b1;
					r.mac = nb_mac[i];
				end
			end
		end
		return r;
	endfunction

	task automatic apply_req(input route_req_t q, input bit typed, input hop_res_t want);
		case (q.op)
			OP_LOOKUP:   hop_q.push_back(typed ? want : resolve_next_hop(q.ip));
			OP_ROUTE_WR: begin
				rt_prefix[q.idx] = q.ip;
				rt_mask[q.idx] = q.mask;
				rt_hop[q.idx] = q.hop;
				rt_port[q.idx] = q.port;
			end
			OP_NBR_WR: begin
				nb_ip[q.idx] = q.ip;
				nb_mac[q.idx] = q.mac;
			end
			default: ;
		endcase
	endtask

	function automatic int unsigned pick_gap(input int unsigned pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 4) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic route_req_t rand_noise();
		route_req_t  q;
		logic [63:0] w;
		w = {$urandom, $urandom};
		q.op = OP_W'($urandom_range(0, 3));
		q.idx = IDX_W'($urandom_range(0, 127));
		q.ip = $urandom;
		q.mask = $urandom;
		q.hop = $urandom;
		q.port = PORT_W'($urandom_range(0, 3));
		q.mac = w[47:0];
		return q;
	endfunction

	function automatic route_req_t rand_route_wr(input logic [IDX_W-1:0] idx);
		route_req_t  q;
		int unsigned len;
		q = rand_noise();
		q.op = OP_ROUTE_WR;
		q.idx = idx;
		len = $urandom_range(0, 32);
		q.mask = 32'hFFFF_FFFF << (32 - len);
		if (len < 31 && $urandom_range(0, 9) == 0)
			q.mask = q.mask | ($urandom & ~(32'hFFFF_FFFF << (31 - len)));
		// mostly a prefix that can match at all
		if ($urandom_range(0, 9) != 0)
			q.ip = q.ip & q.mask;
		if ($urandom_range(0, 4) != 0)
			q.hop = hop_pool[$urandom_range(0, 15)];
		return q;
	endfunction

	function automatic route_req_t rand_nbr_wr(input logic [IDX_W-1:0] idx);
		route_req_t q;
		q = rand_noise();
		q.op = OP_NBR_WR;
		q.idx = idx;
		if ($urandom_range(0, 19) > 2)
			q.ip = hop_pool[$urandom_range(0, 15)];
		return q;
	endfunction

	function automatic route_req_t rand_item();
		route_req_t  q;
		int unsigned pick, j;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			q = rand_noise();
			q.op = OP_LOOKUP;
			// aim most lookups at a stored route
			if ($urandom_range(0, 3) != 0) begin
				j = $urandom_range(0, ROUTES - 1);
				q.ip = rt_prefix[j] | ($urandom & ~rt_mask[j]);
			end
		end else if (pick < 88) begin
			q = rand_route_wr(IDX_W'($urandom_range(0, 127)));
		end else if (pick < 97) begin
			q = rand_nbr_wr(IDX_W'($urandom_range(0, 127)));
		end else begin
			q = rand_noise();
			q.op = OP_UNUSED;
		end
		return q;
	endfunction

	function automatic dir_row_t row_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
		input logic [IP_W-1:0] ip, input logic [IP_W-1:0] mask, input logic [IP_W-1:0] hop,
		input logic [PORT_W-1:0] port, input logic [MAC_W-1:0] mac);
		dir_row_t r;
		r.is_cfg = 1'b0;
		r.typed = 1'b0;
		r.rt_cnt = '0;
		r.nb_cnt = '0;
		r.req = '{op, idx, ip, mask, hop, port, mac};
		r.want = '0;
		return r;
	endfunction

	function automatic dir_row_t row_typed(input logic [IP_W-1:0] ip, input hop_res_t want);
		dir_row_t r;
		r = row_req(OP_LOOKUP, '0, ip, '0, '0, '0, '0);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic dir_row_t row_cfg(input logic [7:0] rt, input logic [7:0] nb);
		dir_row_t r;
		r = row_req(OP_LOOKUP, '0, '0, '0, '0, '0, '0);
		r.is_cfg = 1'b1;
		r.rt_cnt = rt;
		r.nb_cnt = nb;
		return r;
	endfunction

	// valid stays up after an accepted beat; the next call either replaces
	// the payload in the same step or drops valid for a gap
	task automatic send_req(input route_req_t q, input bit typed, input hop_res_t want);
		int unsigned gap;
		gap = pick_gap(req_gap_pct);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= q.op;
		entry_index <= q.idx;
		ip_addr <= q.ip;
		net_mask <= q.mask;
		hop_addr <= q.hop;
		port_num <= q.port;
		hw_addr <= q.mac;
		do @(posedge clk); while (req_stall);
		apply_req(q, typed, want);
	endtask

	task automatic drain_hops(input int unsigned settle);
		req_valid <= 1'b0;
		while (hop_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic program_counts(input logic [7:0] rt, input logic [7:0] nb);
		// trailing table writes give no result, so let them settle too
		drain_hops(SETTLE);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ROUTE_USED;
		cfg_data <= rt;
		do @(posedge clk); while (!cfg_ready);
		rt_used = rt;
		cfg_index <= REG_NEIGHBOR_USED;
		cfg_data <= nb;
		do @(posedge clk); while (!cfg_ready);
		nb_used = nb;
		cfg_valid <= 1'b0;
	endtask

	task automatic check_hop(input hop_res_t got);
		hop_res_t want;
		if (hop_q.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("unexpected rsp beat: found=%0d port=%0d hop=%h nb=%0d mac=%h",
					got.found, got.port, got.hop, got.nb_found, got.mac);
		end else begin
			want = hop_q.pop_front();
			if (got.found !== want.found || got.port !== want.port || got.hop !== want.hop ||
				got.nb_found !== want.nb_found || got.mac !== want.mac) begin
				fail_cnt++;
				if (fail_cnt <= 10) begin
					$display("rsp mismatch: want found=%0d port=%0d hop=%h nb=%0d mac=%h",
						want.found, want.port, want.hop, want.nb_found, want.mac);
					$display("              got  found=%0d port=%0d hop=%h nb=%0d mac=%h",
						got.found, got.port, got.hop, got.nb_found, got.mac);
				end
			end
		end
	endtask

	// rsp side: check accepted beats and pick the stall pattern
	always @(posedge clk) begin : rsp_side
		int unsigned run;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				check_hop({route_found, out_port, next_hop_ip, neighbor_found, dest_mac});
			if (stall_left > 1) begin
				stall_left <= stall_left - 1;
			end else if (long_hold_go && !long_hold_done) begin
				long_hold_done <= 1'b1;
				rsp_stall <= 1'b1;
				stall_left <= LONG_HOLD;
			end else begin
				run = pick_gap(rsp_stall_pct);
				rsp_stall <= (run != 0);
				stall_left <= run;
			end
		end
	end

	initial begin
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		operation <= OP_LOOKUP;
		entry_index <= '0;
		ip_addr <= '0;
		net_mask <= '0;
		hop_addr <= '0;
		port_num <= '0;
		hw_addr <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ROUTE_USED;
		cfg_data <= '0;
		foreach (hop_pool[k])
			hop_pool[k] = $urandom;

		// counts are zero out of reset: nothing can match
		dir_tbl.push_back(row_typed(32'h0A00_0001, '0));
		dir_tbl.push_back(row_req(OP_UNUSED, 7'h7F, '1, '1, '1, '1, '1));
		// default route, /8, /16, host route, /16 tie, mask with holes, /8 tie
		dir_tbl.push_back(row_req(OP_ROUTE_WR, 7'd0, 32'h0, 32'h0, 32'hC0A8_0001, 2'd3, '0));
		dir_tbl.push_back(row_req(OP_ROUTE_WR, 7'd1, 32'h0A00_0000, 32'hFF00_0000,
			32'hC0A8_0002, 2'd1, '0));
		dir_tbl.push_back(row_req(OP_ROUTE_WR, 7'd2, 32'h0A01_0000, 32'hFFFF_0000,
			32'hC0A8_0003, 2'd2, '0));
		dir_tbl.push_back(row_req(OP_ROUTE_WR, 7'd3, 32'h0A01_0203, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 2'd0, '0));
		dir_tbl.push_back(row_req(OP_ROUTE_WR, 7'd4, 32'h0A01_0000, 32'hFFFF_0000,
			32'hC0A8_0004, 2'd3, '0));
		dir_tbl.push_back(row_req(OP_ROUTE_WR, 7'd5, 32'h1400_1400, 32'hFF00_FF00,
			32'hC0A8_0002, 2'd2, '0));
		dir_tbl.push_back(row_req(OP_ROUTE_WR, 7'd6, 32'h1400_0000, 32'hFF00_0000,
			32'hC0A8_0005, 2'd1, '0));
		dir_tbl.push_back(row_req(OP_ROUTE_WR, 7'd127, '1, '1, '0, 2'd3, '0));
		// duplicate neighbor IP: first slot must win
		dir_tbl.push_back(row_req(OP_NBR_WR, 7'd0, 32'hC0A8_0001, '0, '0, '0, '1));
		dir_tbl.push_back(row_req(OP_NBR_WR, 7'd1, 32'hC0A8_0002, '0, '0, '0, 48'h1));
		dir_tbl.push_back(row_req(OP_NBR_WR, 7'd2, 32'hC0A8_0002, '0, '0, '0,
			48'h0A0B_0C0D_0E0F));
		dir_tbl.push_back(row_req(OP_NBR_WR, 7'd3, 32'hC0A8_0003, '0, '0, '0,
			48'h8000_0000_0000));
		dir_tbl.push_back(row_req(OP_NBR_WR, 7'd127, '0, '0, '0, '0, '0));
		dir_tbl.push_back(row_cfg(8'd7, 8'd4));
		// host route wins, its next hop has no neighbor entry
		dir_tbl.push_back(row_typed(32'h0A01_0203, '{1'b1, 2'd0, 32'hFFFF_FFFF, 1'b0, 48'h0}));
		dir_tbl.push_back(row_req(OP_LOOKUP, '0, 32'h0A01_0505, '0, '0, '0, '0));
		dir_tbl.push_back(row_req(OP_LOOKUP, '0, 32'h0A7F_0000, '0, '0, '0, '0));
		dir_tbl.push_back(row_req(OP_LOOKUP, '0, 32'h14AB_14CD, '0, '0, '0, '0));
		dir_tbl.push_back(row_typed(32'hC000_0000,
			'{1'b1, 2'd3, 32'hC0A8_0001, 1'b1, 48'hFFFF_FFFF_FFFF}));
		dir_tbl.push_back(row_cfg(8'd1, 8'd0));
		dir_tbl.push_back(row_typed(32'h1234_5678, '{1'b1, 2'd3, 32'hC0A8_0001, 1'b0, 48'h0}));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		req_gap_pct = 20;
		rsp_stall_pct = 20;
		foreach (dir_tbl[k]) begin
			if (dir_tbl[k].is_cfg)
				program_counts(dir_tbl[k].rt_cnt, dir_tbl[k].nb_cnt);
			else
				send_req(dir_tbl[k].req, dir_tbl[k].typed, dir_tbl[k].want);
		end

		// fill the rest of both tables so any count is safe to search
		req_gap_pct = 10;
		rsp_stall_pct = 30;
		for (int unsigned k = 4; k < 127; k++) begin
			if (k >= 7)
				send_req(rand_route_wr(IDX_W'(k)), 1'b0, '0);
			send_req(rand_nbr_wr(IDX_W'(k)), 1'b0, '0);
		end

		for (int unsigned p = 0; p < PHASES; p++) begin
			case (p)
				0: program_counts(8'd128, 8'd128);
				1: program_counts(8'd255, 8'd255);
				2: program_counts(8'd0, 8'd128);
				3: program_counts(8'd128, 8'd0);
				default: program_counts(8'($urandom_range(0, 128)), 8'($urandom_range(0, 128)));
			endcase
			if (p == 4) begin
				req_gap_pct = 0;
				rsp_stall_pct = 0;
			end else begin
				req_gap_pct = $urandom_range(0, 50);
				rsp_stall_pct = $urandom_range(0, 50);
			end
			// short lookups here, so the block backs up quickly behind the hold
			if (p == 2)
				long_hold_go = 1'b1;
			for (int unsigned k = 0; k < PHASE_LEN; k++) begin
				if (k == PHASE_LEN / 2)
					drain_hops(0);
				send_req(rand_item(), 1'b0, '0);
			end
		end

		drain_hops(SETTLE);
		if (fail_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
